// ===== design/lzw_stream_compressor_macros.svh =====
// assertion macros used by the compressor engine
`ifndef LZW_STREAM_COMPRESSOR_MACROS_SVH
`define LZW_STREAM_COMPRESSOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZWSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lzwsc assertion failed");
`define LZWSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzwsc assertion failed");
`else
`define LZWSC_ASSERT(lbl, prop)
`define LZWSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/lzwsc_pkg.sv =====
package lzwsc_pkg;

  localparam int DictEntries = 4096;
  localparam int CodeW       = 12;
  localparam int CodeLimit   = (DictEntries < 4096) ? DictEntries : 4096;
  localparam int AddrW       = $clog2(CodeLimit);
  localparam int NfcW        = AddrW + 1;
  localparam int FirstFree   = 256;

  typedef enum logic {
    KIND_START,
    KIND_EXTEND
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] out_code;
    logic             last_code;
  } result_t;

  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [7:0]       data_byte;
    logic [CodeW-1:0] sibling;
  } dict_entry_t;

endpackage

// ===== design/lzw_stream_compressor.sv =====
// lzw compressor, 12-bit codes
// input stream: in_tdata[7:0] carries one uncompressed byte per request,
// in_tlast marks the final byte of a message
// output stream: out_tdata[11:0] carries one code, out_tlast marks the
// final code of a message; a byte causes zero, one or two codes
// each message is compressed with a fresh dictionary of up to 4096 codes
// a byte that opens a message is taken in the idle state alone; any other byte
// passes through the head read and then the walk of the children of the current
// prefix in the child chain of the dictionary memory (one registered read
// per child); a final byte adds the closing state for the closing code, and
// the engine takes the next byte only once it is back in the idle state
// a two-entry input queue and a four-entry output queue separate the sides:
// input is taken while codes wait, and a stalled receiver halts the engine
// only once the output queue lacks room for two codes
// reset clears the queues and the control state; the engine then
// clears all 4096 entries of the child-head memory before it takes a request,
// while the input queue fills with up to two requests
// dictionary entries are checked against the current free-code count
module lzw_stream_compressor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] out_code, [15:12] zero
  output logic        out_tlast
);

  logic               q_valid;
  lzwsc_pkg::item_t   q_item;
  logic               q_pop;
  logic               oq_room;
  logic               push;
  lzwsc_pkg::result_t push_res;
  lzwsc_pkg::result_t out_res;

  lzwsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lzwsc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .oq_room  (oq_room),
    .push     (push),
    .push_res (push_res)
  );

  lzwsc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .room      (oq_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(16-lzwsc_pkg::CodeW){1'b0}}, out_res.out_code};
  assign out_tlast = out_res.last_code;

endmodule

// ===== design/lzwsc_front.sv =====
module lzwsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              q_valid,
  output lzwsc_pkg::item_t  q_item,
  input  logic              q_pop
);

  lzwsc_pkg::item_t fifo_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             first_r;
  logic             accept;
  lzwsc_pkg::item_t item_in;

  assign in_ready = (count_r != 2'd2);
  assign accept   = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  // the first byte of a message only opens a prefix
  always_comb begin
    item_in.kind         = first_r ? lzwsc_pkg::KIND_START : lzwsc_pkg::KIND_EXTEND;
    item_in.data_byte    = in_byte;
    item_in.end_of_input = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      first_r  <= 1'b1;
    end else begin
      if (accept) begin
        wr_ptr_r <= ~wr_ptr_r;
        first_r  <= in_last;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (accept && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!accept && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fifo_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== design/lzwsc_out_queue.sv =====
module lzwsc_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lzwsc_pkg::result_t push_res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output lzwsc_pkg::result_t out_res
);

  lzwsc_pkg::result_t buf_r [4];
  logic [1:0]         wr_ptr_r;
  logic [1:0]         rd_ptr_r;
  logic [2:0]         count_r;
  logic               take;

  // room for the two codes one request can cause
  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_res   = buf_r[rd_ptr_r];
  assign take      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      if (push && !take) begin
        count_r <= count_r + 3'd1;
      end else if (!push && take) begin
        count_r <= count_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// ===== design/lzwsc_engine.sv =====
`include "lzw_stream_compressor_macros.svh"

module lzwsc_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lzwsc_pkg::item_t   q_item,
  output logic               q_pop,
  input  logic               oq_room,
  output logic               push,
  output lzwsc_pkg::result_t push_res
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_FIN
  } state_t;

  state_t                            state_r;
  logic [lzwsc_pkg::AddrW-1:0]       clr_r;
  logic [lzwsc_pkg::NfcW-1:0]        nfc_r;
  logic [lzwsc_pkg::CodeW-1:0]       prefix_r;
  logic [7:0]                        byte_r;
  logic                              last_r;
  logic [lzwsc_pkg::CodeW-1:0]       cand_r;
  logic [lzwsc_pkg::CodeW-1:0]       head_r;

  // first child per prefix code, and the pair entries chained by sibling
  logic [lzwsc_pkg::CodeW-1:0]       head_mem [lzwsc_pkg::CodeLimit];
  lzwsc_pkg::dict_entry_t            ent_mem  [lzwsc_pkg::CodeLimit];
  logic [lzwsc_pkg::CodeW-1:0]       head_rdata_r;
  lzwsc_pkg::dict_entry_t            ent_rdata_r;

  logic [lzwsc_pkg::AddrW-1:0]       head_raddr;
  logic [lzwsc_pkg::AddrW-1:0]       ent_raddr;
  logic                              cand_live;
  logic                              more;
  logic                              hit;
  logic                              follow;
  logic                              miss;
  logic                              ins;
  lzwsc_pkg::dict_entry_t            new_entry;

  // a candidate counts only if it was written in this message and hangs off this prefix
  assign cand_live = (cand_r >= lzwsc_pkg::CodeW'(lzwsc_pkg::FirstFree))
                  && ({1'b0, cand_r} < lzwsc_pkg::NfcW'({1'b0, nfc_r}))
                  && (ent_rdata_r.prefix == prefix_r);
  // live siblings always sit at lower codes, a link upwards is left over from an older message
  assign more      = (ent_rdata_r.sibling < cand_r);
  assign hit       = (state_r == S_WALK) && cand_live && (ent_rdata_r.data_byte == byte_r);
  assign follow    = (state_r == S_WALK) && cand_live && !hit && more;
  assign miss      = (state_r == S_WALK) && !hit && !follow;
  assign ins       = miss && (nfc_r < lzwsc_pkg::NfcW'(lzwsc_pkg::CodeLimit));

  assign q_pop      = (state_r == S_IDLE) && q_valid && oq_room;
  assign head_raddr = prefix_r[lzwsc_pkg::AddrW-1:0];
  assign ent_raddr  = (state_r == S_HEAD) ? head_rdata_r[lzwsc_pkg::AddrW-1:0]
                                          : ent_rdata_r.sibling[lzwsc_pkg::AddrW-1:0];

  always_comb begin
    new_entry.prefix    = prefix_r;
    new_entry.data_byte = byte_r;
    new_entry.sibling   = head_r;
  end

  always_comb begin
    push               = 1'b0;
    push_res.out_code  = prefix_r;
    push_res.last_code = 1'b0;
    unique case (state_r)
      S_WALK: begin
        push = miss;
      end
      S_FIN: begin
        push               = 1'b1;
        push_res.last_code = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    head_rdata_r <= head_mem[head_raddr];
    ent_rdata_r  <= ent_mem[ent_raddr];
    if (state_r == S_CLEAR) begin
      head_mem[clr_r] <= '0;
    end else if (ins) begin
      head_mem[head_raddr]                  <= lzwsc_pkg::CodeW'(nfc_r);
      ent_mem[nfc_r[lzwsc_pkg::AddrW-1:0]]  <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      nfc_r   <= lzwsc_pkg::NfcW'(lzwsc_pkg::FirstFree);
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          // one pass over the child heads after reset
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            byte_r <= q_item.data_byte;
            last_r <= q_item.end_of_input;
            if (q_item.kind == lzwsc_pkg::KIND_START) begin
              prefix_r <= {{(lzwsc_pkg::CodeW-8){1'b0}}, q_item.data_byte};
              state_r  <= q_item.end_of_input ? S_FIN : S_IDLE;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          cand_r  <= head_rdata_r;
          head_r  <= head_rdata_r;
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (hit) begin
            prefix_r <= cand_r;
            state_r  <= last_r ? S_FIN : S_IDLE;
          end else if (follow) begin
            cand_r <= ent_rdata_r.sibling;
          end else begin
            prefix_r <= {{(lzwsc_pkg::CodeW-8){1'b0}}, byte_r};
            if (ins) begin
              nfc_r <= nfc_r + 1'b1;
            end
            state_r <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          // fresh dictionary for the next message
          nfc_r   <= lzwsc_pkg::NfcW'(lzwsc_pkg::FirstFree);
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `LZWSC_ASSERT(a_nfc_range, (nfc_r >= lzwsc_pkg::NfcW'(lzwsc_pkg::FirstFree)) && (nfc_r <= lzwsc_pkg::NfcW'(lzwsc_pkg::CodeLimit)))
  `LZWSC_ASSERT_NEXT(a_fin_clears, state_r == S_FIN, nfc_r == lzwsc_pkg::NfcW'(lzwsc_pkg::FirstFree) && state_r == S_IDLE)
  `LZWSC_ASSERT_NEXT(a_ins_counts, ins, nfc_r == $past(nfc_r) + 1'b1)
  `LZWSC_ASSERT(a_pop_only_idle, q_pop |-> (state_r == S_IDLE) && oq_room)

endmodule
